FILE: design/ghp_pkg.sv
// ----------------------------------------------------------------------------
// Generational handle pool package
// Shared widths, default sizes and the action and status codes that the
// channel interfaces and the pool modules use.
// ----------------------------------------------------------------------------
package ghp_pkg;

   localparam int HANDLE_W = 32;

   localparam int CAPACITY_DEFAULT   = 1024;
   localparam int INDEX_BITS_DEFAULT = 16;

   typedef enum logic [1:0] {
      ACT_ALLOC = 2'd0,
      ACT_FREE  = 2'd1,
      ACT_ALIVE = 2'd2,
      ACT_RESET = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_DEAD = 2'd2
   } status_type;

   // Control from the sequencer to the slot table.
   typedef struct packed {
      logic wr_en;   // write the addressed slot
      logic bump;    // a fresh slot was handed out
      logic clear;   // pool reset
   } slot_cmd_type;

   // Control from the sequencer to the free stack.
   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } stack_cmd_type;

endpackage

FILE: design/ghp_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one pool action and its handle per beat.
// ----------------------------------------------------------------------------
interface ghp_req_if;

   logic                          valid;
   logic                          ready;
   ghp_pkg::action_type           action;
   logic [ghp_pkg::HANDLE_W-1:0]  handle;

   modport source (output valid, output action, output handle, input ready);
   modport sink   (input valid, input action, input handle, output ready);

endinterface

FILE: design/ghp_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one pool result per beat.
// ----------------------------------------------------------------------------
interface ghp_rsp_if;

   logic                          valid;
   logic                          ready;
   logic [ghp_pkg::HANDLE_W-1:0]  result_handle;
   logic                          alive;
   ghp_pkg::status_type           status;

   modport source (output valid, output result_handle, output alive, output status,
                   input ready);
   modport sink   (input valid, input result_handle, input alive, input status,
                   output ready);

endinterface

FILE: design/ghp_slot_table.sv
// ----------------------------------------------------------------------------
// Slot table
// One-port-write, one-port-read synchronous memory holding the live handle of
// every slot, plus the count of slots handed out so far.
// ----------------------------------------------------------------------------
module ghp_slot_table #(
   parameter int CAPACITY = ghp_pkg::CAPACITY_DEFAULT,
   parameter int AW       = $clog2(CAPACITY),
   parameter int DW       = $clog2(CAPACITY + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [AW-1:0]                rd_addr,
   input  ghp_pkg::slot_cmd_type        cmd,
   input  logic [AW-1:0]                wr_addr,
   input  logic [ghp_pkg::HANDLE_W-1:0] wr_data,
   output logic [ghp_pkg::HANDLE_W-1:0] rd_data,
   output logic [DW-1:0]                slots_used
);

   logic [ghp_pkg::HANDLE_W-1:0] mem [CAPACITY];
   logic [ghp_pkg::HANDLE_W-1:0] rd_data_ff;
   logic [DW-1:0]                slots_used_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Slot zero is permanently taken and never holds a live handle, so the
   // sequencer never consults its entry and a pool reset only rewinds the count.
   always_ff @(posedge clock) begin
      if (reset) begin
         slots_used_ff <= DW'(1);
      end else if (cmd.clear) begin
         slots_used_ff <= DW'(1);
      end else if (cmd.bump) begin
         slots_used_ff <= slots_used_ff + DW'(1);
      end
   end

   assign rd_data    = rd_data_ff;
   assign slots_used = slots_used_ff;

endmodule

FILE: design/ghp_free_stack.sv
// ----------------------------------------------------------------------------
// Free stack
// LIFO of recycled handles in a synchronous memory. The top entry is read
// into a register every cycle, and a pop uses that registered value.
// ----------------------------------------------------------------------------
module ghp_free_stack #(
   parameter int CAPACITY = ghp_pkg::CAPACITY_DEFAULT,
   parameter int AW       = $clog2(CAPACITY),
   parameter int DW       = $clog2(CAPACITY + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ghp_pkg::stack_cmd_type       cmd,
   input  logic [ghp_pkg::HANDLE_W-1:0] push_data,
   output logic [ghp_pkg::HANDLE_W-1:0] top_data,
   output logic [DW-1:0]                depth
);

   logic [ghp_pkg::HANDLE_W-1:0] mem [CAPACITY];
   logic [ghp_pkg::HANDLE_W-1:0] top_data_ff;
   logic [DW-1:0]                depth_ff;
   logic [DW-1:0]                top_ptr;

   // An empty stack reads entry zero; the value is not used then.
   assign top_ptr = (depth_ff == '0) ? '0 : depth_ff - DW'(1);

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[depth_ff[AW-1:0]] <= push_data;
      end
      top_data_ff <= mem[top_ptr[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else if (cmd.clear) begin
         depth_ff <= '0;
      end else if (cmd.push) begin
         depth_ff <= depth_ff + DW'(1);
      end else if (cmd.pop) begin
         depth_ff <= depth_ff - DW'(1);
      end
   end

   assign top_data = top_data_ff;
   assign depth    = depth_ff;

endmodule

FILE: design/generational_handle_pool.sv
// A request beat is accepted in S_IDLE and resolved in S_LOOKUP, and its result
// is then registered; S_LOOKUP is held while the previous result still waits on
// the response side. Requests are taken only in S_IDLE, one at a time; the slot
// table is read on accept and both memories are written when the lookup finishes.
// Reset: synchronous; the slot count returns to one and the free stack to
// empty at once, with no memory clearing pass, so a request is taken right away.
// ----------------------------------------------------------------------------
// Generational handle pool
// Hands out, recycles and checks 32-bit handles made of a slot index and a
// generation, and resets the whole pool; live and recycled handles are held in memories.
// ----------------------------------------------------------------------------
module generational_handle_pool #(
   parameter int CAPACITY   = ghp_pkg::CAPACITY_DEFAULT,
   parameter int INDEX_BITS = ghp_pkg::INDEX_BITS_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   ghp_req_if.sink  req_chan,
   ghp_rsp_if.source rsp_chan
);

   localparam int HW = ghp_pkg::HANDLE_W;
   localparam int AW = $clog2(CAPACITY);
   localparam int DW = $clog2(CAPACITY + 1);
   localparam logic [HW-1:0] IDX_MASK = (HW'(1) << INDEX_BITS) - HW'(1);
   localparam logic [HW-1:0] GEN_STEP = HW'(1) << INDEX_BITS;
   localparam logic [HW-1:0] CAP_W    = HW'(CAPACITY);

   typedef enum logic {
      S_IDLE,
      S_LOOKUP
   } state_type;

   state_type           state_ff;
   ghp_pkg::action_type action_ff;
   logic [HW-1:0]       handle_ff;

   logic                rsp_valid_ff;
   logic [HW-1:0]       rsp_handle_ff;
   logic                rsp_alive_ff;
   ghp_pkg::status_type rsp_status_ff;

   ghp_pkg::slot_cmd_type  slot_cmd;
   ghp_pkg::stack_cmd_type stack_cmd;
   logic [AW-1:0]          slot_wr_addr;
   logic [HW-1:0]          slot_wr_data;
   logic [HW-1:0]          slot_rd_data;
   logic [DW-1:0]          slots_used;
   logic [HW-1:0]          stack_top;
   logic [DW-1:0]          stack_depth;

   logic                accept;
   logic                finish;
   logic [HW-1:0]       req_idx;
   logic [HW-1:0]       idx;
   logic [HW-1:0]       used_w;
   logic                live;
   logic                fresh_ok;
   logic [HW-1:0]       res_handle;
   logic                res_alive;
   ghp_pkg::status_type res_status;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign finish         = (state_ff == S_LOOKUP) && (!rsp_valid_ff || rsp_chan.ready);

   assign req_idx = req_chan.handle & IDX_MASK;
   assign idx     = handle_ff & IDX_MASK;
   assign used_w  = {{(HW - DW){1'b0}}, slots_used};

   // Index zero never holds a live handle, which also rules out the null handle.
   assign live = (idx != '0) && (idx < used_w) && (idx < CAP_W) && (slot_rd_data == handle_ff);

   assign fresh_ok = (used_w < CAP_W) && (used_w <= IDX_MASK);

   always_comb begin
      slot_cmd     = '0;
      stack_cmd    = '0;
      slot_wr_addr = idx[AW-1:0];
      slot_wr_data = '0;
      res_handle   = '0;
      res_alive    = 1'b0;
      res_status   = ghp_pkg::ST_OK;
      case (action_ff)
         ghp_pkg::ACT_ALLOC: begin
            if (stack_depth != '0) begin
               slot_cmd.wr_en = finish;
               stack_cmd.pop  = finish;
               slot_wr_addr   = stack_top[AW-1:0];
               slot_wr_data   = stack_top;
               res_handle     = stack_top;
            end else if (fresh_ok) begin
               slot_cmd.wr_en = finish;
               slot_cmd.bump  = finish;
               slot_wr_addr   = slots_used[AW-1:0];
               slot_wr_data   = used_w;
               res_handle     = used_w;
            end else begin
               res_status = ghp_pkg::ST_FULL;
            end
         end
         ghp_pkg::ACT_FREE: begin
            if (live && (stack_depth < DW'(CAPACITY))) begin
               slot_cmd.wr_en = finish;
               stack_cmd.push = finish;
            end else begin
               res_status = ghp_pkg::ST_DEAD;
            end
         end
         ghp_pkg::ACT_ALIVE: begin
            res_alive = live;
         end
         ghp_pkg::ACT_RESET: begin
            slot_cmd.clear  = finish;
            stack_cmd.clear = finish;
         end
         default: begin
            res_status = ghp_pkg::ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_LOOKUP;
               end
            end
            S_LOOKUP: begin
               if (finish) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         action_ff <= req_chan.action;
         handle_ff <= req_chan.handle;
      end
      if (finish) begin
         rsp_handle_ff <= res_handle;
         rsp_alive_ff  <= res_alive;
         rsp_status_ff <= res_status;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.result_handle = rsp_handle_ff;
   assign rsp_chan.alive         = rsp_alive_ff;
   assign rsp_chan.status        = rsp_status_ff;

   ghp_slot_table #(
      .CAPACITY (CAPACITY),
      .AW       (AW),
      .DW       (DW)
   ) u_slot_table (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (accept),
      .rd_addr    (req_idx[AW-1:0]),
      .cmd        (slot_cmd),
      .wr_addr    (slot_wr_addr),
      .wr_data    (slot_wr_data),
      .rd_data    (slot_rd_data),
      .slots_used (slots_used)
   );

   ghp_free_stack #(
      .CAPACITY (CAPACITY),
      .AW       (AW),
      .DW       (DW)
   ) u_free_stack (
      .clock     (clock),
      .reset     (reset),
      .cmd       (stack_cmd),
      .push_data (handle_ff + GEN_STEP),
      .top_data  (stack_top),
      .depth     (stack_depth)
   );

endmodule
